/* rtl/dvr_pkg.sv */
// Shared widths, request codes and error codes of the dense value remapper.
`timescale 1ns / 1ps
package dvr_pkg;

    localparam int VALUE_BITS_DEF = 10;
    localparam int REQ_W          = 3;
    localparam int IN_W           = 10;
    localparam int OUT_W          = 10;
    localparam int COUNT_W        = 11;
    localparam int ERR_W          = 2;

    localparam logic [COUNT_W-1:0] VALUE_COUNT_RST = 11'd1024;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR = 3'd0,
        REQ_MARK  = 3'd1,
        REQ_BUILD = 3'd2,
        REQ_MAP   = 3'd3,
        REQ_DICT  = 3'd4
    } t_req;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE    = 2'd0,
        ERR_RANGE   = 2'd1,
        ERR_UNBUILT = 2'd2
    } t_err;

endpackage

/* rtl/dvr_ram.sv */
// Simple dual-port memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
module dvr_ram #(
    parameter int DATA_W = dvr_pkg::OUT_W,
    parameter int ADDR_W = dvr_pkg::VALUE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/dense_value_remapper.sv */
// Mark, map and dictionary-read items: one per cycle while the block is idle and the output is not stalled.
// Each result passes the read of the rank or dictionary memory, then the output register.
// Clear: writes every rank memory entry, one memory entry written per cycle.
// Build: reads the rank memory entries below the effective value_count, one rank memory read per cycle.
// Reset starts the same clearing pass; no item is accepted until it ends.
// Configuration writes are taken at any time.
`timescale 1ns / 1ps
module dense_value_remapper #(
    parameter int VALUE_BITS = dvr_pkg::VALUE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [dvr_pkg::COUNT_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [dvr_pkg::REQ_W-1:0]   i_req_type,
    input  logic [dvr_pkg::IN_W-1:0]    i_in_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [dvr_pkg::OUT_W-1:0]   o_out_value,
    output logic [dvr_pkg::COUNT_W-1:0] o_out_count,
    output logic                       o_out_found,
    output logic [dvr_pkg::ERR_W-1:0]   o_out_error
);
    import dvr_pkg::*;

    localparam int DEPTH  = 1 << VALUE_BITS;
    localparam int ADDR_W = VALUE_BITS;

    typedef struct packed {
        logic             present;
        logic [OUT_W-1:0] rank;
    } t_rank_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLEAR,
        S_BUILD,
        S_BUILD_TAIL
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_idx;
    logic [COUNT_W-1:0]  r_left;
    logic                r_wb_valid;
    logic [ADDR_W-1:0]   r_wb_addr;
    logic [COUNT_W-1:0]  r_unique;
    logic                r_built;
    logic [COUNT_W-1:0]  r_value_count;

    logic                r_s1_valid;
    logic [REQ_W-1:0]    r_s1_req;
    logic [ERR_W-1:0]    r_s1_err;
    logic                r_s1_ok;

    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_value;
    logic [COUNT_W-1:0]  r_out_count;
    logic                r_out_found;
    logic [ERR_W-1:0]    r_out_error;

    logic [COUNT_W-1:0]  eff_count;
    logic                in_range;
    logic                dict_range;
    logic                out_free;
    logic                s1_move;
    logic                in_ready;
    logic                in_acc;

    logic [ERR_W-1:0]    n_s1_err;
    logic                n_s1_ok;
    logic [OUT_W-1:0]    n_out_value;
    logic                n_out_found;

    logic                rank_we;
    logic [ADDR_W-1:0]   rank_waddr;
    t_rank_entry         rank_wdata;
    logic                rank_re;
    logic [ADDR_W-1:0]   rank_raddr;
    t_rank_entry         rank_rd;

    logic                dict_we;
    logic [ADDR_W-1:0]   dict_waddr;
    logic [OUT_W-1:0]    dict_wdata;
    logic                dict_re;
    logic [OUT_W-1:0]    dict_rd;

    assign eff_count  = (int'(r_value_count) > DEPTH) ? COUNT_W'(DEPTH) : r_value_count;
    assign in_range   = COUNT_W'(i_in_value) < eff_count;
    assign dict_range = COUNT_W'(i_in_value) < r_unique;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && (r_state == S_IDLE) && out_free;
    assign in_ready   = (r_state == S_IDLE) && (!r_s1_valid || s1_move);
    assign in_acc     = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;

    always_comb begin
        n_s1_err = ERR_NONE;
        n_s1_ok  = 1'b0;
        case (i_req_type)
            REQ_MARK: begin
                n_s1_err = in_range ? ERR_NONE : ERR_RANGE;
            end
            REQ_MAP: begin
                n_s1_ok = r_built && in_range;
                if (!r_built) begin
                    n_s1_err = ERR_UNBUILT;
                end else if (!in_range) begin
                    n_s1_err = ERR_RANGE;
                end
            end
            REQ_DICT: begin
                n_s1_ok  = dict_range;
                n_s1_err = dict_range ? ERR_NONE : ERR_RANGE;
            end
            default: begin
                n_s1_err = ERR_NONE;
            end
        endcase
    end

    always_comb begin
        n_out_value = '0;
        n_out_found = 1'b0;
        case (r_s1_req)
            REQ_MAP: begin
                if (r_s1_ok && rank_rd.present) begin
                    n_out_found = 1'b1;
                    n_out_value = rank_rd.rank;
                end
            end
            REQ_DICT: begin
                if (r_s1_ok) begin
                    n_out_found = 1'b1;
                    n_out_value = dict_rd;
                end
            end
            default: begin
                n_out_found = 1'b0;
            end
        endcase
    end

    always_comb begin
        rank_we    = 1'b0;
        rank_waddr = '0;
        rank_wdata = '0;
        dict_we    = 1'b0;
        dict_waddr = ADDR_W'(r_unique);
        dict_wdata = OUT_W'(r_wb_addr);
        if (r_state == S_CLEAR) begin
            rank_we    = 1'b1;
            rank_waddr = r_idx;
        end else if (r_wb_valid) begin
            rank_we            = 1'b1;
            rank_waddr         = r_wb_addr;
            rank_wdata.present = rank_rd.present;
            rank_wdata.rank    = rank_rd.present ? OUT_W'(r_unique) : '0;
            dict_we            = rank_rd.present;
        end else if (in_acc && (i_req_type == REQ_MARK) && in_range) begin
            rank_we            = 1'b1;
            rank_waddr         = ADDR_W'(i_in_value);
            rank_wdata.present = 1'b1;
        end
    end

    always_comb begin
        if (r_state == S_BUILD) begin
            rank_re    = 1'b1;
            rank_raddr = r_idx;
        end else begin
            rank_re    = in_acc && (i_req_type == REQ_MAP);
            rank_raddr = ADDR_W'(i_in_value);
        end
    end

    assign dict_re = in_acc && (i_req_type == REQ_DICT);

    dvr_ram #(
        .DATA_W ($bits(t_rank_entry)),
        .ADDR_W (ADDR_W)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rank_we),
        .i_waddr (rank_waddr),
        .i_wdata (rank_wdata),
        .i_re    (rank_re),
        .i_raddr (rank_raddr),
        .o_rdata (rank_rd)
    );

    dvr_ram #(
        .DATA_W (OUT_W),
        .ADDR_W (ADDR_W)
    ) u_dict_ram (
        .i_clk   (i_clk),
        .i_we    (dict_we),
        .i_waddr (dict_waddr),
        .i_wdata (dict_wdata),
        .i_re    (dict_re),
        .i_raddr (ADDR_W'(i_in_value)),
        .o_rdata (dict_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_idx         <= '0;
            r_left        <= '0;
            r_wb_valid    <= 1'b0;
            r_unique      <= '0;
            r_built       <= 1'b0;
            r_value_count <= VALUE_COUNT_RST;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_value_count <= i_cfg_wdata;
                r_built       <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_req_type)
                            REQ_CLEAR: begin
                                r_state  <= S_CLEAR;
                                r_idx    <= '0;
                                r_unique <= '0;
                                r_built  <= 1'b0;
                            end
                            REQ_MARK: begin
                                if (in_range) begin
                                    r_built <= 1'b0;
                                end
                            end
                            REQ_BUILD: begin
                                r_unique <= '0;
                                r_idx    <= '0;
                                r_left   <= eff_count;
                                if (eff_count == '0) begin
                                    r_built <= 1'b1;
                                end else begin
                                    r_state <= S_BUILD;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == {ADDR_W{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_BUILD: begin
                    r_idx  <= r_idx + 1'b1;
                    r_left <= r_left - 1'b1;
                    if (r_left == COUNT_W'(1)) begin
                        r_state <= S_BUILD_TAIL;
                    end
                end
                S_BUILD_TAIL: begin
                    r_state <= S_IDLE;
                    r_built <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            r_wb_valid <= (r_state == S_BUILD);
            if (r_wb_valid && rank_rd.present) begin
                r_unique <= r_unique + 1'b1;
            end

            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        r_wb_addr <= r_idx;

        if (in_acc) begin
            r_s1_req <= i_req_type;
            r_s1_err <= n_s1_err;
            r_s1_ok  <= n_s1_ok;
        end

        if (s1_move) begin
            r_out_value <= n_out_value;
            r_out_count <= r_unique;
            r_out_found <= n_out_found;
            r_out_error <= r_s1_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_count = r_out_count;
    assign o_out_found = r_out_found;
    assign o_out_error = r_out_error;

endmodule

/* tb/tb_dense_value_remapper.sv */
// Self-checking testbench for dense_value_remapper: directed and random requests with a predicting scoreboard.
`timescale 1ns / 1ps
module tb_dense_value_remapper;
    import dvr_pkg::*;

    localparam int TABLE_DEPTH   = 1 << VALUE_BITS_DEF;
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 64;
    localparam int QUIET_LIMIT   = 20000;
    localparam int PHASE_ITEMS   = 240;
    localparam int NUM_PHASES    = 8;
    localparam int SHOWN_ERRORS  = 20;

    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [OUT_W-1:0]   value;
        logic [COUNT_W-1:0] count;
        logic               found;
        t_err               err;
    } remap_result_t;

    class remap_scoreboard;
        bit                 present_map [TABLE_DEPTH];
        logic [OUT_W-1:0]   rank_of [TABLE_DEPTH];
        logic [OUT_W-1:0]   value_at_rank [TABLE_DEPTH];
        logic [COUNT_W-1:0] distinct_count;
        bit                 ranks_valid;
        logic [COUNT_W-1:0] value_limit;
        remap_result_t      pending_results [$];
        int                 mismatches;
        int                 results_checked;
        int                 requests_seen;
        int                 req_counts [8];

        function new();
            foreach (present_map[i]) begin
                present_map[i]   = 1'b0;
                rank_of[i]       = '0;
                value_at_rank[i] = '0;
            end
            foreach (req_counts[i]) req_counts[i] = 0;
            distinct_count  = '0;
            ranks_valid     = 1'b0;
            value_limit     = VALUE_COUNT_RST;
            mismatches      = 0;
            results_checked = 0;
            requests_seen   = 0;
        endfunction

        function int unsigned usable_values();
            return (value_limit > TABLE_DEPTH) ? TABLE_DEPTH : value_limit;
        endfunction

        function void write_limit(logic [COUNT_W-1:0] v);
            value_limit = v;
            ranks_valid = 1'b0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [IN_W-1:0] v);
            remap_result_t r;
            int unsigned   lim;
            r   = '0;
            lim = usable_values();
            requests_seen++;
            req_counts[req]++;
            case (req)
                REQ_CLEAR: begin
                    foreach (present_map[i]) begin
                        present_map[i] = 1'b0;
                        rank_of[i]     = '0;
                    end
                    distinct_count = '0;
                    ranks_valid    = 1'b0;
                end
                REQ_MARK: begin
                    if (v >= lim) begin
                        r.err = ERR_RANGE;
                    end else begin
                        present_map[v] = 1'b1;
                        ranks_valid    = 1'b0;
                    end
                end
                REQ_BUILD: begin
                    distinct_count = '0;
                    for (int unsigned i = 0; i < lim; i++) begin
                        if (present_map[i]) begin
                            rank_of[i] = distinct_count[OUT_W-1:0];
                            value_at_rank[distinct_count[OUT_W-1:0]] = i[OUT_W-1:0];
                            distinct_count++;
                        end else begin
                            rank_of[i] = '0;
                        end
                    end
                    ranks_valid = 1'b1;
                end
                REQ_MAP: begin
                    if (!ranks_valid) begin
                        r.err = ERR_UNBUILT;
                    end else if (v >= lim) begin
                        r.err = ERR_RANGE;
                    end else if (present_map[v]) begin
                        r.found = 1'b1;
                        r.value = rank_of[v];
                    end
                end
                REQ_DICT: begin
                    if (v < distinct_count) begin
                        r.found = 1'b1;
                        r.value = value_at_rank[v];
                    end else begin
                        r.err = ERR_RANGE;
                    end
                end
                default: begin
                end
            endcase
            r.count = distinct_count;
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= SHOWN_ERRORS) $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_result(logic [OUT_W-1:0] value, logic [COUNT_W-1:0] count,
                          logic found, logic [ERR_W-1:0] err);
            remap_result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request waiting");
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (value !== want.value)
                report_mismatch($sformatf("result %0d out_value %0d, want %0d",
                                          results_checked, value, want.value));
            if (count !== want.count)
                report_mismatch($sformatf("result %0d out_count %0d, want %0d",
                                          results_checked, count, want.count));
            if (found !== want.found)
                report_mismatch($sformatf("result %0d out_found %0b, want %0b",
                                          results_checked, found, want.found));
            if (err !== want.err)
                report_mismatch($sformatf("result %0d out_error %0d, want %0d",
                                          results_checked, err, want.err));
        endtask
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [COUNT_W-1:0]   i_cfg_wdata = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [REQ_W-1:0]     i_req_type  = '0;
    logic [IN_W-1:0]      i_in_value  = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [OUT_W-1:0]     o_out_value;
    logic [COUNT_W-1:0]   o_out_count;
    logic                 o_out_found;
    logic [ERR_W-1:0]     o_out_error;

    remap_scoreboard      sb;
    int                   gap_pct     = 0;
    int                   stall_pct   = 0;
    int                   items_sent  = 0;
    int                   quiet_cycles = 0;
    int                   settings_used = 1;
    int unsigned          cur_limit   = TABLE_DEPTH;
    logic [IN_W-1:0]      marked_values [$];
    logic [COUNT_W-1:0]   phase_limits [NUM_PHASES];

    dense_value_remapper u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_in_value  (i_in_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_value (o_out_value),
        .o_out_count (o_out_count),
        .o_out_found (o_out_found),
        .o_out_error (o_out_error)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_request(i_req_type, i_in_value);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_out_value, o_out_count, o_out_found, o_out_error);
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [REQ_W-1:0] req, input logic [IN_W-1:0] v);
        while ((gap_pct != 0) && ($urandom_range(0, 99) < gap_pct)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_in_value <= v;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        items_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_value_count(input logic [COUNT_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.write_limit(v);
        i_cfg_we  <= 1'b0;
        cur_limit = (v > TABLE_DEPTH) ? TABLE_DEPTH : v;
        settings_used++;
    endtask

    function automatic logic [IN_W-1:0] pick_source();
        if (cur_limit != 0 && $urandom_range(0, 9) < 8)
            return IN_W'($urandom_range(0, cur_limit - 1));
        return IN_W'($urandom_range(0, TABLE_DEPTH - 1));
    endfunction

    function automatic logic [IN_W-1:0] pick_marked();
        if (marked_values.size() != 0 && $urandom_range(0, 1) == 0)
            return marked_values[$urandom_range(0, marked_values.size() - 1)];
        return pick_source();
    endfunction

    task automatic send_mark();
        logic [IN_W-1:0] v;
        v = pick_source();
        marked_values.push_back(v);
        send_item(REQ_MARK, v);
    endtask

    task automatic send_noise();
        send_item(REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)),
                  IN_W'($urandom_range(0, TABLE_DEPTH - 1)));
    endtask

    task automatic random_round();
        int n_marks;
        int n_queries;
        int pick;
        if ($urandom_range(0, 9) != 0) begin
            send_item(REQ_CLEAR, IN_W'($urandom_range(0, TABLE_DEPTH - 1)));
            marked_values.delete();
        end
        n_marks = $urandom_range(1, 24);
        repeat (n_marks) begin
            if ($urandom_range(0, 19) == 0) send_noise();
            else send_mark();
        end
        if ($urandom_range(0, 19) == 0) send_item(REQ_MAP, pick_marked());
        send_item(REQ_BUILD, IN_W'($urandom_range(0, TABLE_DEPTH - 1)));
        n_queries = $urandom_range(4, 20);
        repeat (n_queries) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_item(REQ_MAP, pick_marked());
            end else if (pick < 85) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(REQ_DICT, IN_W'($urandom_range(0, TABLE_DEPTH - 1)));
                else
                    send_item(REQ_DICT, IN_W'($urandom_range(0, marked_values.size() + 2)));
            end else if (pick < 92) begin
                send_mark();
            end else if (pick < 96) begin
                send_noise();
            end else begin
                send_item(REQ_BUILD, IN_W'($urandom_range(0, TABLE_DEPTH - 1)));
            end
        end
    endtask

    initial begin
        int phase_start;
        sb = new();
        phase_limits = '{11'd1024, 11'd0, 11'd1, 11'd2047, 11'd1024,
                         COUNT_W'($urandom_range(2, 1023)), 11'd1023,
                         COUNT_W'($urandom_range(0, 2047))};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(REQ_MAP, 10'd5);
        send_item(REQ_DICT, 10'd0);
        send_item(REQ_UNUSED_LO, 10'd1023);
        send_item(REQ_UNUSED_HI, 10'd0);
        send_item(REQ_MARK, 10'd0);
        send_item(REQ_MARK, 10'd1023);
        send_item(REQ_MARK, 10'h155);
        send_item(REQ_MARK, 10'h2AA);
        send_item(REQ_MARK, 10'd512);
        send_item(REQ_MARK, 10'd0);
        send_item(REQ_BUILD, 10'd0);
        send_item(REQ_MAP, 10'd0);
        send_item(REQ_MAP, 10'd1023);
        send_item(REQ_MAP, 10'h2AA);
        send_item(REQ_MAP, 10'd7);
        send_item(REQ_DICT, 10'd0);
        send_item(REQ_DICT, 10'd4);
        send_item(REQ_DICT, 10'd5);
        send_item(REQ_MARK, 10'd3);
        send_item(REQ_MAP, 10'd3);
        send_item(REQ_BUILD, 10'd0);
        send_item(REQ_MAP, 10'd3);
        send_item(REQ_CLEAR, 10'd0);
        send_item(REQ_MAP, 10'd0);
        send_item(REQ_DICT, 10'd0);
        drain_results();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase != 0) begin
                drain_results();
                repeat (SETTLE_CYCLES) @(posedge i_clk);
                write_value_count(phase_limits[phase]);
            end
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 46; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 46; end
                default: begin gap_pct = 21; stall_pct = 21; end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) random_round();
        end

        drain_results();
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        $display("Covered %0d requests, %0d results checked, %0d value_count settings.",
                 sb.requests_seen, sb.results_checked, settings_used);
        $display("Requests: %0d clears, %0d marks, %0d builds, %0d maps, %0d dictionary reads.",
                 sb.req_counts[REQ_CLEAR], sb.req_counts[REQ_MARK], sb.req_counts[REQ_BUILD],
                 sb.req_counts[REQ_MAP], sb.req_counts[REQ_DICT]);
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
